FILE: src/swpw_pkg.sv
// Shared types and constants of the single-wire pulse-width master.
// Used by the top level and by its port checker; depends on nothing.
package swpw_pkg;

	localparam int unsigned WORD_BITS = 13;
	localparam int unsigned TICK_WIDTH = 24;
	localparam int unsigned TAU_WIDTH = 12;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_SEND  = 3'd1;
	localparam logic [2:0] OP_RECV  = 3'd2;
	localparam logic [2:0] OP_PWRUP = 3'd3;
	localparam logic [2:0] OP_PWRDN = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TRAINING = 2'd1;
	localparam logic [1:0] ST_BIT_TO   = 2'd2;
	localparam logic [1:0] ST_RESP_TO  = 2'd3;

	localparam logic [1:0] REG_TAU      = 2'd0;
	localparam logic [1:0] REG_PWR_UP   = 2'd1;
	localparam logic [1:0] REG_PWR_OFF  = 2'd2;

	localparam logic [3:0] LAST_BIT = 4'(WORD_BITS - 1);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_SEND  = 3'd1,
		MODE_RECV  = 3'd2,
		MODE_PWRUP = 3'd3,
		MODE_PWRDN = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_BITS  = 2'd1,
		PH_END   = 2'd2
	} phase_t;

	// code, byte, inversion bit; invert low code bits and byte when ones dominate
	function automatic logic [WORD_BITS-1:0] encode_word(input logic [3:0] code,
			input logic [7:0] data);
		logic [3:0] ones;
		logic inv;
		logic [3:0] c;
		logic [7:0] d;
		ones = 4'($countones({code, data}));
		inv = (ones > 4'd6);
		c = inv ? (code ^ 4'h3) : code;
		d = inv ? ~data : data;
		return {c, d, inv};
	endfunction

endpackage

FILE: src/single_wire_pulse_width_master.sv
// Top level of the single-wire pulse-width master: tick channel, result channel,
// configuration registers and the send / receive / power sequencer.
// Depends on swpw_pkg.
//
// Usage: every transfer on the item channel is one tick of the wire timing. It
// carries the command (operation, tx_code, tx_data) and the sampled wire level
// line_in. Each item yields exactly one result: drive_enable / drive_level for
// the wire, busy_res and done_res for the running operation, and the last
// received byte and status. Commands are taken only on a tick that finds the
// block idle; while busy they are ignored.
// An item is held in the input register, then its result is loaded into the
// result register. Throughput: one item per cycle while the receiver does not
// stall; the sequencer update is a single pass of logic between the input
// register and the result register.
// The receiver may stall: the result register holds, the input register fills,
// and item_ready drops only while both are full and result_ready is low.
// Reset: sequencer idle, timing registers at their defaults, results empty.
// Configuration (tau, power-up and power-down ticks) is written over the APB port
// by the user only while no operation runs (not enforced); pready is always high.
module single_wire_pulse_width_master #(
	parameter int unsigned COUNT_WIDTH = 15
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [3:0]  tx_code,
	input  logic [7:0]  tx_data,
	input  logic        line_in,

	output logic        result_valid,
	input  logic        result_ready,
	output logic        drive_enable,
	output logic        drive_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic [1:0]  status,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swpw_pkg::*;

	localparam int unsigned EXT_WIDTH = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;

	// configuration
	logic [TAU_WIDTH-1:0]  tau_q;
	logic [13:0]           tau3_q;
	logic [14:0]           tau5_q;
	logic [17:0]           tau50_q;
	logic [TICK_WIDTH-1:0] pwr_up_q;
	logic [TICK_WIDTH-1:0] pwr_off_q;
	logic                  cfg_wr;
	logic [TAU_WIDTH-1:0]  tau_w;

	// input stage
	logic                 valid_s1;
	logic [2:0]           op_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic                 line_s1;
	logic                 advance;

	// sequencer state
	mode_t                 mode_q, mode_n, mode_e;
	phase_t                phase_q, phase_n, phase_e;
	logic [3:0]            bit_q, bit_n, bit_e;
	logic [TICK_WIDTH-1:0] tick_q, tick_n, tick_e, tick_inc;
	logic [WORD_BITS-1:0]  txw_q, txw_n, txw_e;
	logic                  exp_q, exp_n;
	logic [7:0]            rxb_q, rxb_n;
	logic [1:0]            stat_q, stat_n;
	logic [COUNT_WIDTH-1:0] period_q [WORD_BITS];
	logic [COUNT_WIDTH-1:0] lo_q, hi_q, lo_n, hi_n;
	logic                  pw_en;

	// receive decode
	logic [EXT_WIDTH-1:0]   tick_ext;
	logic [COUNT_WIDTH-1:0] period_v;
	logic [COUNT_WIDTH:0]   mid_sum;
	logic [COUNT_WIDTH-1:0] mid;
	logic [WORD_BITS-1:0]   rx_word;
	logic [7:0]             rx_dec;
	logic                   start;
	logic [13:0]            bit_len;

	// tick outputs
	logic en_c, lvl_c, busy_c, done_c;

	// result register
	logic       result_valid_q;
	logic       drive_enable_q, drive_level_q, busy_q, done_q;
	logic [7:0] rx_byte_q;
	logic [1:0] status_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign tau_w  = pwdata[TAU_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q     <= 12'd100;
			tau3_q    <= 14'd300;
			tau5_q    <= 15'd500;
			tau50_q   <= 18'd5000;
			pwr_up_q  <= 24'd100000;
			pwr_off_q <= 24'd200000;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TAU: begin
					tau_q   <= tau_w;
					tau3_q  <= {1'b0, tau_w, 1'b0} + {2'b0, tau_w};
					tau5_q  <= {1'b0, tau_w, 2'b0} + {3'b0, tau_w};
					tau50_q <= {1'b0, tau_w, 5'b0} + {2'b0, tau_w, 4'b0}
						+ {5'b0, tau_w, 1'b0};
				end
				REG_PWR_UP:  pwr_up_q  <= pwdata[TICK_WIDTH-1:0];
				REG_PWR_OFF: pwr_off_q <= pwdata[TICK_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TAU:     prdata = {20'b0, tau_q};
			REG_PWR_UP:  prdata = {8'b0, pwr_up_q};
			REG_PWR_OFF: prdata = {8'b0, pwr_off_q};
			default:     prdata = '0;
		endcase
	end

	// handshake: the input stage advances whenever the result register frees up
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// encode the send word on the way in to keep the sequencer pass short
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_s1   <= operation;
			word_s1 <= encode_word(tx_code, tx_data);
			line_s1 <= line_in;
		end
	end

	// effective state for this tick: a command in idle restarts the counters
	assign start = (mode_q == MODE_IDLE) && (op_s1 == OP_SEND || op_s1 == OP_RECV
		|| op_s1 == OP_PWRUP || op_s1 == OP_PWRDN);

	always_comb begin
		mode_e  = mode_q;
		phase_e = phase_q;
		bit_e   = bit_q;
		tick_e  = tick_q;
		txw_e   = txw_q;
		if (start) begin
			phase_e = PH_START;
			bit_e   = '0;
			tick_e  = '0;
			unique case (op_s1)
				OP_SEND: begin
					mode_e = MODE_SEND;
					txw_e  = word_s1;
				end
				OP_RECV:  mode_e = MODE_RECV;
				OP_PWRUP: mode_e = MODE_PWRUP;
				default:  mode_e = MODE_PWRDN;
			endcase
		end
	end

	assign tick_inc = tick_e + 1'b1;
	assign tick_ext = EXT_WIDTH'(tick_e);
	assign period_v = tick_ext[COUNT_WIDTH-1:0];
	assign bit_len  = txw_e[bit_e] ? tau3_q : {2'b0, tau_q};

	// running min and max of the stored periods, including this one
	always_comb begin
		if (bit_e == LAST_BIT) begin
			lo_n = period_v;
			hi_n = period_v;
		end else begin
			lo_n = (period_v < lo_q) ? period_v : lo_q;
			hi_n = (period_v > hi_q) ? period_v : hi_q;
		end
	end

	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid     = mid_sum[COUNT_WIDTH:1];

	always_comb begin
		rx_word[0] = period_v > mid;
		for (int i = 1; i < WORD_BITS; i++) begin
			rx_word[i] = period_q[i] > mid;
		end
		rx_dec = rx_word[0] ? ~rx_word[8:1] : rx_word[8:1];
	end

	always_comb begin
		mode_n  = mode_e;
		phase_n = phase_e;
		bit_n   = bit_e;
		tick_n  = tick_e;
		txw_n   = txw_e;
		exp_n   = exp_q;
		rxb_n   = rxb_q;
		stat_n  = stat_q;
		pw_en   = 1'b0;
		en_c    = 1'b0;
		lvl_c   = 1'b0;
		busy_c  = 1'b0;
		done_c  = 1'b0;
		unique case (mode_e)
			MODE_SEND: begin
				busy_c = 1'b1;
				en_c   = 1'b1;
				unique case (phase_e)
					PH_START: begin
						lvl_c  = 1'b1;
						tick_n = tick_inc;
						if (tick_inc >= TICK_WIDTH'(tau5_q)) begin
							phase_n = PH_BITS;
							bit_n   = LAST_BIT;
							tick_n  = '0;
						end
					end
					PH_BITS: begin
						lvl_c  = bit_e[0];
						tick_n = tick_inc;
						if (tick_inc >= TICK_WIDTH'(bit_len)) begin
							tick_n = '0;
							if (bit_e == 4'd0) begin
								phase_n = PH_END;
							end else begin
								bit_n = bit_e - 1'b1;
							end
						end
					end
					default: begin
						lvl_c  = 1'b1;
						done_c = 1'b1;
						stat_n = ST_OK;
						mode_n = MODE_IDLE;
					end
				endcase
			end
			MODE_RECV: begin
				busy_c = 1'b1;
				if (phase_e == PH_START) begin
					if (!line_s1) begin
						phase_n = PH_BITS;
						bit_n   = LAST_BIT;
						exp_n   = 1'b0;
						tick_n  = TICK_WIDTH'(1);
					end else begin
						tick_n = tick_inc;
						if (tick_inc >= TICK_WIDTH'(tau50_q)) begin
							done_c = 1'b1;
							stat_n = ST_RESP_TO;
							rxb_n  = '0;
							mode_n = MODE_IDLE;
						end
					end
				end else if (line_s1 == exp_q) begin
					tick_n = tick_inc;
					if (tick_inc >= TICK_WIDTH'(tau5_q)) begin
						done_c = 1'b1;
						stat_n = ST_BIT_TO;
						rxb_n  = '0;
						mode_n = MODE_IDLE;
					end
				end else begin
					// level changed: close this period
					pw_en = 1'b1;
					if (bit_e == 4'd0) begin
						done_c = 1'b1;
						mode_n = MODE_IDLE;
						if (rx_word[12] == rx_word[11]) begin
							stat_n = ST_TRAINING;
							rxb_n  = '0;
						end else begin
							stat_n = ST_OK;
							rxb_n  = rx_dec;
						end
					end else begin
						bit_n  = bit_e - 1'b1;
						exp_n  = ~exp_q;
						tick_n = TICK_WIDTH'(1);
					end
				end
			end
			MODE_PWRUP, MODE_PWRDN: begin
				busy_c = 1'b1;
				if (phase_e == PH_START) begin
					en_c   = 1'b1;
					lvl_c  = (mode_e == MODE_PWRUP);
					tick_n = tick_inc;
					if (tick_inc >= ((mode_e == MODE_PWRUP) ? pwr_up_q : pwr_off_q)) begin
						phase_n = PH_END;
					end
				end else begin
					done_c = 1'b1;
					stat_n = ST_OK;
					mode_n = MODE_IDLE;
				end
			end
			default: mode_n = MODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			phase_q <= PH_START;
			bit_q   <= '0;
			tick_q  <= '0;
			txw_q   <= '0;
			exp_q   <= 1'b0;
			rxb_q   <= '0;
			stat_q  <= ST_OK;
		end else if (advance) begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			bit_q   <= bit_n;
			tick_q  <= tick_n;
			txw_q   <= txw_n;
			exp_q   <= exp_n;
			rxb_q   <= rxb_n;
			stat_q  <= stat_n;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pw_en) begin
			period_q[bit_e] <= period_v;
			lo_q            <= lo_n;
			hi_q            <= hi_n;
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_enable_q <= en_c;
			drive_level_q  <= lvl_c;
			busy_q         <= busy_c;
			done_q         <= done_c;
			rx_byte_q      <= rxb_n;
			status_q       <= stat_n;
		end
	end

	assign result_valid = result_valid_q;
	assign drive_enable = drive_enable_q;
	assign drive_level  = drive_level_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign rx_byte      = rx_byte_q;
	assign status       = status_q;

endmodule

FILE: src/swpw_checker.sv
// Port-level checker for the single-wire pulse-width master, bound to the top level.
// Depends on swpw_pkg and on the top level's port names.
module swpw_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic       drive_enable,
	input logic       drive_level,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rx_byte,
	input logic [1:0] status
);
	import swpw_pkg::*;

	// a stalled result transfer holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable({drive_enable, drive_level, busy_res, done_res, rx_byte, status}))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_res |-> busy_res)
		else $error("done outside an operation");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !drive_enable |-> !drive_level)
		else $error("level driven while released");

	// every failed receive clears the byte, and only receives set an error
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> rx_byte == 8'd0)
		else $error("error status with nonzero byte");

endmodule

bind single_wire_pulse_width_master swpw_checker u_swpw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.drive_enable (drive_enable),
	.drive_level  (drive_level),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.rx_byte      (rx_byte),
	.status       (status)
);

FILE: tb/pulse_width_check_pkg.sv
// Scoreboard for the single-wire pulse-width master: tick-accurate predictor plus result checker.
// Depends on swpw_pkg for operation, status, register and state codes.
package pulse_width_check_pkg;
	import swpw_pkg::*;

	localparam int unsigned PERIOD_BITS = 15;

	typedef struct packed {
		logic       drive_en;
		logic       drive_lvl;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic [1:0] status;
	} tick_result_t;

	class pulse_width_scoreboard;
		logic [TAU_WIDTH-1:0]   tau;
		logic [TICK_WIDTH-1:0]  up_ticks;
		logic [TICK_WIDTH-1:0]  off_ticks;

		mode_t                  mode;
		phase_t                 phase;
		logic [3:0]             bit_idx;
		logic [TICK_WIDTH-1:0]  tick_cnt;
		logic [WORD_BITS-1:0]   tx_bits;
		logic                   want_level;
		logic [PERIOD_BITS-1:0] periods [WORD_BITS];
		logic [7:0]             held_byte;
		logic [1:0]             held_status;

		tick_result_t expected_ticks[$];

		int errors;
		int checked;
		int busy_ticks;
		int sends;
		int receives;
		int powers;
		int outcome [4];

		function new();
			tau = 12'd100;
			up_ticks = 24'd100000;
			off_ticks = 24'd200000;
			mode = MODE_IDLE;
			phase = PH_START;
			bit_idx = '0;
			tick_cnt = '0;
			tx_bits = '0;
			want_level = 1'b0;
			foreach (periods[i]) periods[i] = '0;
			held_byte = '0;
			held_status = ST_OK;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_TAU:     tau = value[TAU_WIDTH-1:0];
				REG_PWR_UP:  up_ticks = value[TICK_WIDTH-1:0];
				REG_PWR_OFF: off_ticks = value[TICK_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// advance the segment counter; true once the segment length is reached
		function bit step_counter(int unsigned len);
			tick_cnt = tick_cnt + 1'b1;
			return {8'b0, tick_cnt} >= len;
		endfunction

		function void finish_receive(logic [1:0] st, logic [7:0] b);
			held_status = st;
			held_byte = b;
			mode = MODE_IDLE;
			outcome[st]++;
		endfunction

		// one accepted tick: work out the result it produces
		function void note_item(logic [2:0] op, logic [3:0] code, logic [7:0] data, logic line);
			tick_result_t r;
			int unsigned t, ones, lo, hi, mid;
			logic inv, bitv;
			logic [3:0] c;
			logic [7:0] d;
			logic [WORD_BITS-1:0] wrd;
			r = '0;
			t = tau;
			if (mode == MODE_IDLE && op >= OP_SEND && op <= OP_PWRDN) begin
				phase = PH_START;
				bit_idx = '0;
				tick_cnt = '0;
				case (op)
					OP_SEND: begin
						ones = $countones({code, data});
						inv = (ones > 6);
						c = inv ? (code ^ 4'h3) : code;
						d = inv ? ~data : data;
						tx_bits = {c, d, inv};
						mode = MODE_SEND;
						sends++;
					end
					OP_RECV: begin
						mode = MODE_RECV;
						receives++;
					end
					OP_PWRUP: begin
						mode = MODE_PWRUP;
						powers++;
					end
					default: begin
						mode = MODE_PWRDN;
						powers++;
					end
				endcase
			end

			case (mode)
				MODE_SEND: begin
					r.busy = 1'b1;
					r.drive_en = 1'b1;
					if (phase == PH_START) begin
						r.drive_lvl = 1'b1;
						if (step_counter(5 * t)) begin
							phase = PH_BITS;
							bit_idx = LAST_BIT;
							tick_cnt = '0;
						end
					end else if (phase == PH_BITS) begin
						bitv = tx_bits[bit_idx];
						r.drive_lvl = bit_idx[0];
						if (step_counter(bitv ? 3 * t : t)) begin
							tick_cnt = '0;
							if (bit_idx == 0)
								phase = PH_END;
							else
								bit_idx = bit_idx - 1'b1;
						end
					end else begin
						r.drive_lvl = 1'b1;
						r.done = 1'b1;
						held_status = ST_OK;
						mode = MODE_IDLE;
					end
				end
				MODE_RECV: begin
					r.busy = 1'b1;
					if (phase == PH_START) begin
						if (!line) begin
							phase = PH_BITS;
							bit_idx = LAST_BIT;
							want_level = 1'b0;
							tick_cnt = 1;
						end else if (step_counter(50 * t)) begin
							r.done = 1'b1;
							finish_receive(ST_RESP_TO, 8'h00);
						end
					end else if (line == want_level) begin
						if (step_counter(5 * t)) begin
							r.done = 1'b1;
							finish_receive(ST_BIT_TO, 8'h00);
						end
					end else begin
						periods[bit_idx] = tick_cnt[PERIOD_BITS-1:0];
						if (bit_idx == 0) begin
							r.done = 1'b1;
							// threshold halfway between shortest and longest period
							lo = periods[0];
							hi = periods[0];
							foreach (periods[i]) begin
								if (periods[i] < lo) lo = periods[i];
								if (periods[i] > hi) hi = periods[i];
							end
							mid = (lo + hi) / 2;
							foreach (periods[i]) wrd[i] = (periods[i] > mid);
							if (wrd[WORD_BITS-1] == wrd[WORD_BITS-2])
								finish_receive(ST_TRAINING, 8'h00);
							else
								finish_receive(ST_OK, wrd[0] ? ~wrd[8:1] : wrd[8:1]);
						end else begin
							bit_idx = bit_idx - 1'b1;
							want_level = ~want_level;
							tick_cnt = 1;
						end
					end
				end
				MODE_PWRUP, MODE_PWRDN: begin
					r.busy = 1'b1;
					if (phase == PH_START) begin
						r.drive_en = 1'b1;
						r.drive_lvl = (mode == MODE_PWRUP);
						if (step_counter(mode == MODE_PWRUP ? up_ticks : off_ticks))
							phase = PH_END;
					end else begin
						r.done = 1'b1;
						held_status = ST_OK;
						mode = MODE_IDLE;
					end
				end
				default: mode = MODE_IDLE;
			endcase

			if (r.busy) busy_ticks++;
			r.rx_byte = held_byte;
			r.status = held_status;
			expected_ticks.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_ticks.size() == 0) begin
				$error("result transfer with nothing pending: %h", got);
				errors++;
				return;
			end
			want = expected_ticks.pop_front();
			checked++;
			compare_field("drive_enable", want.drive_en, got.drive_en);
			compare_field("drive_level", want.drive_lvl, got.drive_lvl);
			compare_field("busy_res", want.busy, got.busy);
			compare_field("done_res", want.done, got.done);
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
			compare_field("status", want.status, got.status);
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the single-wire pulse-width master: drives ticks, APB writes and
// result stalls, and checks every result transfer. Depends on swpw_pkg and pulse_width_check_pkg.
module tb_top;
	import swpw_pkg::*;
	import pulse_width_check_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef enum int {RX_CLEAN, RX_TRAINING, RX_BIT_TIMEOUT, RX_RESP_TIMEOUT} rx_case_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [2:0]  operation;
	logic [3:0]  tx_code;
	logic [7:0]  tx_data;
	logic        line_in;
	logic        result_valid;
	logic        result_ready;
	logic        drive_enable;
	logic        drive_level;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic [1:0]  status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pulse_width_scoreboard sb;
	bit tx_fast;
	int cycles;

	single_wire_pulse_width_master #(
		.COUNT_WIDTH(PERIOD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.tx_code(tx_code),
		.tx_data(tx_data),
		.line_in(line_in),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.drive_enable(drive_enable),
		.drive_level(drive_level),
		.busy_res(busy_res),
		.done_res(done_res),
		.rx_byte(rx_byte),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// offer one tick and hold it until the transfer
	task automatic offer(logic [2:0] op, logic [3:0] code, logic [7:0] data, logic line);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		tx_code <= code;
		tx_data <= data;
		line_in <= line;
		do @(posedge clk); while (!(item_valid && item_ready));
		sb.note_item(op, code, data, line);
		if ($urandom_range(0, 49) == 0) tx_fast = !tx_fast;
	endtask

	task automatic run_busy();
		while (sb.mode != MODE_IDLE)
			offer(3'($urandom_range(0, 7)), 4'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic idle_noise(int n);
		logic [2:0] op;
		repeat (n) begin
			// codes above power down are unassigned and act as a plain tick
			op = 3'($urandom_range(0, 3));
			if (op != OP_TICK) op = op + OP_PWRDN;
			offer(op, 4'($urandom), 8'($urandom), 1'($urandom));
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic do_send(logic [3:0] code, logic [7:0] data);
		offer(OP_SEND, code, data, 1'($urandom));
		run_busy();
	endtask

	task automatic do_power(logic [2:0] op);
		offer(op, 4'($urandom), 8'($urandom), 1'($urandom));
		run_busy();
	endtask

	// ticks of one wire period for a bit, kept below the bit timeout
	function automatic int period_ticks(logic one, int t);
		if (t <= 1) return (one && t == 1) ? $urandom_range(3, 4) : 1;
		return one ? $urandom_range(5, (5 * t - 1 < 12) ? 5 * t - 1 : 12) : $urandom_range(1, 2);
	endfunction

	task automatic do_receive(logic [WORD_BITS-1:0] wrd, rx_case_t kind);
		logic plan[$];
		int t, len, bad, i;
		logic lvl;
		t = sb.tau;
		if (kind == RX_TRAINING)
			wrd[WORD_BITS-2] = wrd[WORD_BITS-1];
		else
			wrd[WORD_BITS-2] = ~wrd[WORD_BITS-1];
		bad = $urandom_range(0, WORD_BITS - 1);
		if (t > 0) repeat ($urandom_range(0, 4)) plan.push_back(1'b1);
		if (kind != RX_RESP_TIMEOUT) begin
			for (i = WORD_BITS - 1; i >= 0; i--) begin
				len = period_ticks(wrd[i], t);
				if (kind == RX_BIT_TIMEOUT && i == bad) len = 5 * t + 2;
				repeat (len) plan.push_back(1'(i % 2));
			end
			// rising edge that closes the last period
			plan.push_back(1'b1);
		end
		lvl = (plan.size() != 0) ? plan.pop_front() : 1'b1;
		offer(OP_RECV, 4'($urandom), 8'($urandom), lvl);
		while (sb.mode != MODE_IDLE) begin
			lvl = (plan.size() != 0) ? plan.pop_front() : 1'b1;
			offer(3'($urandom_range(0, 7)), 4'($urandom), 8'($urandom), lvl);
		end
	endtask

	task automatic random_phase(int goal);
		int start, pick;
		bit quick, power_ok;
		start = sb.busy_ticks;
		while (sb.busy_ticks - start < goal) begin
			quick = (sb.tau <= 8);
			power_ok = (sb.up_ticks <= 64) && (sb.off_ticks <= 64);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				idle_noise($urandom_range(1, 3));
			else if (pick < 33 && quick)
				do_send(4'(pick_byte()), pick_byte());
			else if (pick < 43 && power_ok)
				do_power(pick < 38 ? OP_PWRUP : OP_PWRDN);
			else if (pick < 50)
				do_receive(13'($urandom), RX_TRAINING);
			else if (pick < 56 && quick)
				do_receive(13'($urandom), RX_BIT_TIMEOUT);
			else if (pick < 60 && quick)
				do_receive(13'($urandom), RX_RESP_TIMEOUT);
			else
				do_receive(13'($urandom), RX_CLEAN);
		end
	endtask

	// drain all results before touching the registers
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_transfer(bit write, logic [1:0] idx, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(logic [1:0] idx);
		logic [31:0] rd, want;
		apb_transfer(1'b0, idx, 32'h0, rd);
		case (idx)
			REG_TAU:    want = {20'b0, sb.tau};
			REG_PWR_UP: want = {8'b0, sb.up_ticks};
			default:    want = {8'b0, sb.off_ticks};
		endcase
		if (rd !== want) begin
			$error("register %0d readback: expected %0h, got %0h", idx, want, rd);
			sb.errors++;
		end
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		logic [31:0] data, rd;
		data = value;
		// stray bits above the register width must be dropped
		if ($urandom_range(0, 1)) data = data | ($urandom << (idx == REG_TAU ? TAU_WIDTH : TICK_WIDTH));
		apb_transfer(1'b1, idx, data, rd);
		sb.set_register(idx, data);
		check_register(idx);
	endtask

	task automatic load_timing(logic [31:0] tau, logic [31:0] up, logic [31:0] off);
		settle();
		write_register(REG_TAU, tau);
		write_register(REG_PWR_UP, up);
		write_register(REG_PWR_OFF, off);
	endtask

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
		$display("Verification failed");
		$finish;
	end

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int gap, seen;
		bit rx_fast, held;
		seen = 0;
		rx_fast = 1'b0;
		held = 1'b0;
		result_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = rx_fast ? 0 : $urandom_range(0, 19);
			if (!held && seen == 250) begin
				gap = 150;
				held = 1'b1;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			sb.check_result({drive_enable, drive_level, busy_res, done_res, rx_byte, status});
			seen++;
			if ($urandom_range(0, 59) == 0) rx_fast = !rx_fast;
		end
	end

	initial begin
		sb = new();
		tx_fast = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = OP_TICK;
		tx_code = 4'h0;
		tx_data = 8'h00;
		line_in = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'h0;
		pwdata = 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, then short receives at the default tau
		check_register(REG_TAU);
		check_register(REG_PWR_UP);
		check_register(REG_PWR_OFF);
		offer(OP_TICK, 4'h0, 8'h00, 1'b0);
		idle_noise(4);
		do_receive(13'h0A5B, RX_CLEAN);
		do_receive(13'h1234, RX_TRAINING);

		load_timing(32'd1, 32'd3, 32'd0);
		do_send(4'h0, 8'h00);
		do_send(4'hF, 8'hFF);
		do_send(4'h3, 8'h0F);
		do_send(4'h7, 8'h0F);
		do_power(OP_PWRUP);
		do_power(OP_PWRDN);
		do_receive(13'h1A5F, RX_CLEAN);
		do_receive(13'h0FFE, RX_TRAINING);
		do_receive(13'h1555, RX_BIT_TIMEOUT);
		do_receive(13'h0AAA, RX_RESP_TIMEOUT);
		random_phase(250);

		load_timing(32'd0, 32'd0, 32'd2);
		random_phase(120);

		load_timing(32'd2, 32'd7, 32'd5);
		random_phase(450);

		load_timing(32'd4095, 32'hFF_FFFF, 32'hFF_FFFF);
		random_phase(150);

		load_timing(32'd3, 32'd1, 32'd1);
		random_phase(250);

		settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d sends, %0d power operations, %0d receives (%0d ok, %0d training, %0d bit timeout, %0d response timeout)",
				sb.sends, sb.powers, sb.receives, sb.outcome[ST_OK], sb.outcome[ST_TRAINING],
				sb.outcome[ST_BIT_TO], sb.outcome[ST_RESP_TO]);
		$display("  %0d busy ticks, %0d results checked, %0d errors", sb.busy_ticks,
				sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
src/swpw_pkg.sv
src/single_wire_pulse_width_master.sv
src/swpw_checker.sv
tb/pulse_width_check_pkg.sv
tb/tb_top.sv
